/* src/key_debounce_autorepeat_defines.svh */
// Assertion macros for the key debounce and auto-repeat block
`ifndef KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define KDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key debounce check failed (same cycle)");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define KDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key debounce check failed (next cycle)");

`endif

/* src/kda_pkg.sv */
// Types and constants shared by the key debounce and auto-repeat block
`timescale 1ns / 1ps

package kda_pkg;

  localparam int unsigned TICKS_PER_UNIT = 10;
  localparam int unsigned TICK_W         = 12;
  localparam int unsigned KEY_W          = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_W          = 8;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
  localparam logic [KEY_W-1:0] KEY_UP    = 3'd1;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd2;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd3;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_DELAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_AFTER     = 3'd4;

  typedef enum logic {
    PH_DEBOUNCE = 1'b0,
    PH_WAIT     = 1'b1
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [TICK_W-1:0]   tick;
    logic [KEY_W-1:0]    cand;
    logic [KEY_W-1:0]    held;
    logic                first;
    logic [CFG_W-1:0]    rep_cnt;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:   PH_DEBOUNCE,
    tick:    '0,
    cand:    KEY_NONE,
    held:    KEY_NONE,
    first:   1'b1,
    rep_cnt: '0
  };

  // Priority encoder over the active-low button levels
  function automatic logic [KEY_W-1:0] encode_keys(input logic up_n, input logic left_n,
                                                   input logic right_n, input logic down_n);
    logic [KEY_W-1:0] code;
    code = KEY_NONE;
    if (!down_n)  code = KEY_DOWN;
    if (!right_n) code = KEY_RIGHT;
    if (!left_n)  code = KEY_LEFT;
    if (!up_n)    code = KEY_UP;
    return code;
  endfunction

endpackage

/* src/kda_if.sv */
// Handshake channel interfaces of the key debounce and auto-repeat block
`timescale 1ns / 1ps

interface kda_key_if;
  logic valid;
  logic ready;
  logic up_n;
  logic left_n;
  logic right_n;
  logic down_n;

  modport source (output valid, up_n, left_n, right_n, down_n, input ready);
  modport sink   (input valid, up_n, left_n, right_n, down_n, output ready);
endinterface

interface kda_code_if;
  logic                          valid;
  logic                          ready;
  logic [kda_pkg::KEY_W-1:0]     key_code;

  modport source (output valid, key_code, input ready);
  modport sink   (input valid, key_code, output ready);
endinterface

interface kda_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kda_pkg::CFG_IDX_W-1:0]  index;
  logic [kda_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/key_debounce_autorepeat.sv */
// Top level: debounced four-button reader with auto-repeat
`timescale 1ns / 1ps
`include "key_debounce_autorepeat_defines.svh"

// Usage
// - key_i: one request per 1 ms tick, carrying the four active-low button
//   levels. Priority up, left, right, down picks the key code.
// - code_o: key code 1..4 for each press or repeat; most ticks give nothing.
// - cfg_i: register writes (0 debounce ticks, 1 first delay, 2 repeat delay,
//   3 fast delay, 4 fast-after count); always ready, unknown indexes ignored.
//   Write only while no tick is in flight.
// Timing
// - A request is held in an input register, then stepped through the state
//   update into the output register once that register can take its result;
//   the result is offered to code_o from the output register.
// - Throughput is one request per cycle while code_o does not stall; the limit
//   is the single state update stage, whose next-state logic is compares, a
//   counter step and a small multiply by ten.
// - If code_o stalls with a result pending, the input register fills and
//   key_i.ready drops; nothing is lost or repeated.
// Reset
// - rst_ni low clears the state to idle and loads the default delays
//   (10, 50, 20, 5, 30). Both registers are emptied.
module key_debounce_autorepeat (
  input  logic               clk_i,
  input  logic               rst_ni,
  kda_key_if.sink            key_i,
  kda_code_if.source         code_o,
  kda_cfg_if.sink            cfg_i
);

  // Configuration registers
  logic [kda_pkg::CFG_W-1:0] deb_ticks_q, first_dly_q, rep_dly_q, fast_dly_q, fast_after_q;

  // Input register
  logic       in_vld_q;
  logic [3:0] in_lvl_q;   // {down_n, right_n, left_n, up_n}

  // Output register
  logic                       out_vld_q;
  logic [kda_pkg::KEY_W-1:0]  code_q;

  kda_pkg::state_t st_q, st_d;

  logic                       res_vld;
  logic [kda_pkg::KEY_W-1:0]  res_code;
  logic [kda_pkg::KEY_W-1:0]  key_c;
  logic                       do_start, do_fin;
  logic [kda_pkg::CFG_W-1:0]  units;
  logic [kda_pkg::TICK_W-1:0] hold_ticks;

  logic slot_free, step_en;

  // A stored request is stepped whenever the output register can take its result
  assign slot_free   = !out_vld_q || code_o.ready;
  assign step_en     = in_vld_q && slot_free;
  assign key_i.ready = !in_vld_q || step_en;
  assign cfg_i.ready = 1'b1;

  assign code_o.valid    = out_vld_q;
  assign code_o.key_code = code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= 8'd10;
      first_dly_q  <= 8'd50;
      rep_dly_q    <= 8'd20;
      fast_dly_q   <= 8'd5;
      fast_after_q <= 8'd30;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kda_pkg::CFG_DEBOUNCE_TICKS: deb_ticks_q  <= cfg_i.data;
        kda_pkg::CFG_FIRST_DELAY:    first_dly_q  <= cfg_i.data;
        kda_pkg::CFG_REPEAT_DELAY:   rep_dly_q    <= cfg_i.data;
        kda_pkg::CFG_FAST_DELAY:     fast_dly_q   <= cfg_i.data;
        kda_pkg::CFG_FAST_AFTER:     fast_after_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (key_i.ready) begin
      in_vld_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      in_lvl_q <= {key_i.down_n, key_i.right_n, key_i.left_n, key_i.up_n};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= kda_pkg::STATE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (step_en) begin
        st_q <= st_d;
      end
      if (slot_free) begin
        out_vld_q <= step_en && res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && res_vld) begin
      code_q <= res_code;
    end
  end

  // One tick of the debounce / repeat state machine
  always_comb begin
    st_d     = st_q;
    res_vld  = 1'b0;
    res_code = kda_pkg::KEY_NONE;
    do_start = 1'b0;
    do_fin   = 1'b0;
    units    = '0;
    hold_ticks = '0;
    key_c    = kda_pkg::encode_keys(in_lvl_q[0], in_lvl_q[1], in_lvl_q[2], in_lvl_q[3]);

    if (st_q.phase == kda_pkg::PH_WAIT) begin
      if (key_c != st_q.held) begin
        // release or change: back to idle, then take up the new code
        st_d.held  = kda_pkg::KEY_NONE;
        st_d.first = 1'b1;
        st_d.phase = kda_pkg::PH_DEBOUNCE;
        st_d.cand  = kda_pkg::KEY_NONE;
        st_d.tick  = '0;
        do_start   = 1'b1;
      end else begin
        if (st_q.tick != '0) begin
          st_d.tick = st_q.tick - kda_pkg::TICK_W'(1);
        end
        if (st_d.tick == '0) begin
          st_d.phase = kda_pkg::PH_DEBOUNCE;
          st_d.cand  = kda_pkg::KEY_NONE;
          // up and down time out silently
          if (st_q.held != kda_pkg::KEY_UP && st_q.held != kda_pkg::KEY_DOWN) begin
            res_vld  = 1'b1;
            res_code = st_q.held;
          end
        end
      end
    end else begin
      if (st_q.cand == kda_pkg::KEY_NONE || key_c != st_q.cand) begin
        if (st_q.cand != kda_pkg::KEY_NONE) begin
          st_d.held  = kda_pkg::KEY_NONE;
          st_d.first = 1'b1;
          st_d.phase = kda_pkg::PH_DEBOUNCE;
          st_d.cand  = kda_pkg::KEY_NONE;
          st_d.tick  = '0;
        end
        do_start = 1'b1;
      end else begin
        if (st_q.tick != kda_pkg::TICK_MAX) begin
          st_d.tick = st_q.tick + kda_pkg::TICK_W'(1);
        end
        if (st_d.tick >= kda_pkg::TICK_W'(deb_ticks_q)) begin
          do_fin = 1'b1;
        end
      end
    end

    if (do_start) begin
      if (key_c == kda_pkg::KEY_NONE) begin
        st_d.held  = kda_pkg::KEY_NONE;
        st_d.first = 1'b1;
        st_d.phase = kda_pkg::PH_DEBOUNCE;
        st_d.cand  = kda_pkg::KEY_NONE;
        st_d.tick  = '0;
      end else begin
        if (st_d.held != kda_pkg::KEY_NONE && key_c != st_d.held) begin
          st_d.held  = kda_pkg::KEY_NONE;
          st_d.first = 1'b1;
        end
        st_d.phase = kda_pkg::PH_DEBOUNCE;
        st_d.cand  = key_c;
        st_d.tick  = kda_pkg::TICK_W'(1);
        // a window of zero or one tick completes at once
        if (deb_ticks_q <= kda_pkg::CFG_W'(1)) begin
          do_fin = 1'b1;
        end
      end
    end

    if (do_fin) begin
      if (st_d.held == kda_pkg::KEY_NONE) begin
        // first press report
        st_d.held    = st_d.cand;
        st_d.rep_cnt = '0;
        st_d.cand    = kda_pkg::KEY_NONE;
        st_d.tick    = '0;
        res_vld      = 1'b1;
        res_code     = st_d.held;
      end else begin
        if (st_d.first) begin
          units        = first_dly_q;
          st_d.first   = 1'b0;
          st_d.rep_cnt = kda_pkg::CFG_W'(1);
        end else if (st_d.rep_cnt >= fast_after_q) begin
          units        = fast_dly_q;
          st_d.rep_cnt = fast_after_q;
        end else begin
          units        = rep_dly_q;
          st_d.rep_cnt = st_d.rep_cnt + kda_pkg::CFG_W'(1);
        end
        hold_ticks = kda_pkg::TICK_W'(units) * kda_pkg::TICK_W'(kda_pkg::TICKS_PER_UNIT);
        st_d.tick  = (hold_ticks == '0) ? kda_pkg::TICK_W'(1) : hold_ticks;
        st_d.cand  = kda_pkg::KEY_NONE;
        st_d.phase = kda_pkg::PH_WAIT;
      end
    end
  end

  // Checks
  `KDA_ASSERT_NOW(a_wait_has_key, st_q.phase == kda_pkg::PH_WAIT,
                  st_q.held != kda_pkg::KEY_NONE && st_q.tick != '0 &&
                  st_q.cand == kda_pkg::KEY_NONE)
  `KDA_ASSERT_NOW(a_idle_first, st_q.held == kda_pkg::KEY_NONE, st_q.first)
  `KDA_ASSERT_NEXT(a_result_lands, step_en && res_vld,
                   out_vld_q && code_q == $past(res_code))
  `KDA_ASSERT_NOW(a_result_code_ok, out_vld_q,
                  code_q != kda_pkg::KEY_NONE && code_q <= kda_pkg::KEY_DOWN)

endmodule

/* tb/key_debounce_autorepeat_test.sv */
// Self-checking testbench for the key debounce and auto-repeat block
`timescale 1ns / 1ps

module key_debounce_autorepeat_test;

  // Button levels of one tick request, active low: {down_n, right_n, left_n, up_n}
  typedef logic [3:0] levels_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_TOGGLE,
    READY_SPARSE,
    READY_RARE
  } sink_mode_e;

  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES = 8;     // input reg + state stage, with margin

  // Register indexes the block does not decode
  localparam logic [kda_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [kda_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam levels_t LV_NONE  = 4'b1111;
  localparam levels_t LV_ALL   = 4'b0000;
  localparam levels_t LV_LEFT  = 4'b1101;
  localparam levels_t LV_RIGHT = 4'b1011;
  localparam levels_t LV_DOWN  = 4'b0111;
  localparam levels_t LV_LR    = 4'b1001;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kda_key_if  key_ch ();
  kda_code_if code_ch ();
  kda_cfg_if  cfg_ch ();

  key_debounce_autorepeat u_dut (
    .clk_i,
    .rst_ni,
    .key_i  (key_ch),
    .code_o (code_ch),
    .cfg_i  (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predicted block state and register copies, reset values
  // ---------------------------------------------------------------------------
  kda_pkg::phase_e            ph         = kda_pkg::PH_DEBOUNCE;
  logic [kda_pkg::TICK_W-1:0] tick_cnt   = '0;   // debounce ticks so far, or hold ticks left
  logic [kda_pkg::KEY_W-1:0]  cand_key   = kda_pkg::KEY_NONE;
  logic [kda_pkg::KEY_W-1:0]  held_key   = kda_pkg::KEY_NONE;
  logic                       first_hold = 1'b1;
  logic [kda_pkg::CFG_W-1:0]  rep_cnt    = '0;

  logic [kda_pkg::CFG_W-1:0]  db_ticks   = 8'd10;
  logic [kda_pkg::CFG_W-1:0]  first_dly  = 8'd50;
  logic [kda_pkg::CFG_W-1:0]  rep_dly    = 8'd20;
  logic [kda_pkg::CFG_W-1:0]  fast_dly   = 8'd5;
  logic [kda_pkg::CFG_W-1:0]  fast_after = 8'd30;

  // Key codes still owed by the block, oldest first
  logic [kda_pkg::KEY_W-1:0]  code_queue[$];
  // Tick requests waiting for the driver
  levels_t                    pending[$];

  int unsigned queued_ticks   = 0;
  int unsigned accepted_ticks = 0;
  int unsigned idle_cycles    = 0;
  int unsigned errors         = 0;
  bit          key_taken      = 1'b0;

  // Priority up, left, right, down
  function automatic logic [kda_pkg::KEY_W-1:0] key_from_levels(levels_t lv);
    if (!lv[0]) return kda_pkg::KEY_UP;
    if (!lv[1]) return kda_pkg::KEY_LEFT;
    if (!lv[2]) return kda_pkg::KEY_RIGHT;
    if (!lv[3]) return kda_pkg::KEY_DOWN;
    return kda_pkg::KEY_NONE;
  endfunction

  task automatic release_keys();
    held_key   = kda_pkg::KEY_NONE;
    first_hold = 1'b1;
    ph         = kda_pkg::PH_DEBOUNCE;
    cand_key   = kda_pkg::KEY_NONE;
    tick_cnt   = '0;
  endtask

  // Debounce window done: either the first press, or the start of a hold wait
  task automatic close_window(output bit hit, output logic [kda_pkg::KEY_W-1:0] code);
    logic [kda_pkg::CFG_W-1:0] units;
    hit  = 1'b0;
    code = kda_pkg::KEY_NONE;
    if (held_key == kda_pkg::KEY_NONE) begin
      held_key = cand_key;
      rep_cnt  = '0;
      cand_key = kda_pkg::KEY_NONE;
      tick_cnt = '0;
      hit      = 1'b1;
      code     = held_key;
    end else begin
      if (first_hold) begin
        units      = first_dly;
        first_hold = 1'b0;
        rep_cnt    = 8'd1;
      end else if (rep_cnt >= fast_after) begin
        rep_cnt = fast_after;  // saturates here
        units   = fast_dly;
      end else begin
        rep_cnt = rep_cnt + kda_pkg::CFG_W'(1);
        units   = rep_dly;
      end
      tick_cnt = kda_pkg::TICK_W'(units) * kda_pkg::TICK_W'(kda_pkg::TICKS_PER_UNIT);
      // a zero delay still costs one tick
      if (tick_cnt == '0) tick_cnt = kda_pkg::TICK_W'(1);
      cand_key = kda_pkg::KEY_NONE;
      ph       = kda_pkg::PH_WAIT;
    end
  endtask

  // Start debouncing code c; a change of key drops the held one first
  task automatic open_window(input logic [kda_pkg::KEY_W-1:0] c, output bit hit,
                             output logic [kda_pkg::KEY_W-1:0] code);
    hit  = 1'b0;
    code = kda_pkg::KEY_NONE;
    if (c == kda_pkg::KEY_NONE) begin
      release_keys();
    end else begin
      if (held_key != kda_pkg::KEY_NONE && c != held_key) release_keys();
      ph       = kda_pkg::PH_DEBOUNCE;
      cand_key = c;
      tick_cnt = kda_pkg::TICK_W'(1);
      // zero debounce behaves as one tick
      if (tick_cnt >= kda_pkg::TICK_W'(db_ticks)) close_window(hit, code);
    end
  endtask

  // One 1 ms tick: at most one key code out
  task automatic predict_tick(input levels_t lv, output bit hit,
                              output logic [kda_pkg::KEY_W-1:0] code);
    logic [kda_pkg::KEY_W-1:0] c;
    c    = key_from_levels(lv);
    hit  = 1'b0;
    code = kda_pkg::KEY_NONE;
    if (ph == kda_pkg::PH_WAIT) begin
      if (c != held_key) begin
        release_keys();
        open_window(c, hit, code);
      end else begin
        if (tick_cnt != '0) tick_cnt = tick_cnt - kda_pkg::TICK_W'(1);
        if (tick_cnt == '0) begin
          ph       = kda_pkg::PH_DEBOUNCE;
          cand_key = kda_pkg::KEY_NONE;
          // up and down keep their timing but never repeat
          if (held_key != kda_pkg::KEY_UP && held_key != kda_pkg::KEY_DOWN) begin
            hit  = 1'b1;
            code = held_key;
          end
        end
      end
    end else if (cand_key == kda_pkg::KEY_NONE || c != cand_key) begin
      if (cand_key != kda_pkg::KEY_NONE) release_keys();
      open_window(c, hit, code);
    end else begin
      if (tick_cnt < kda_pkg::TICK_MAX) tick_cnt = tick_cnt + kda_pkg::TICK_W'(1);
      if (tick_cnt >= kda_pkg::TICK_W'(db_ticks)) close_window(hit, code);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted ticks and returned key codes, all seen
  // at the rising edge. Also the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    bit                        hit;
    bit                        progress;
    logic [kda_pkg::KEY_W-1:0] code;
    logic [kda_pkg::KEY_W-1:0] want;
    progress  = 1'b0;
    key_taken <= key_ch.valid && key_ch.ready;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        progress = 1'b1;
        case (cfg_ch.index)
          kda_pkg::CFG_DEBOUNCE_TICKS: db_ticks   = cfg_ch.data;
          kda_pkg::CFG_FIRST_DELAY:    first_dly  = cfg_ch.data;
          kda_pkg::CFG_REPEAT_DELAY:   rep_dly    = cfg_ch.data;
          kda_pkg::CFG_FAST_DELAY:     fast_dly   = cfg_ch.data;
          kda_pkg::CFG_FAST_AFTER:     fast_after = cfg_ch.data;
          default: ;  // unused index, ignored
        endcase
      end
      if (key_ch.valid && key_ch.ready) begin
        progress = 1'b1;
        accepted_ticks++;
        predict_tick({key_ch.down_n, key_ch.right_n, key_ch.left_n, key_ch.up_n}, hit, code);
        if (hit) code_queue.push_back(code);
      end
      if (code_ch.valid && code_ch.ready) begin
        progress = 1'b1;
        if (code_queue.size() == 0) begin
          errors++;
          $error("key_code: none expected, actual %0d", code_ch.key_code);
        end else begin
          want = code_queue.pop_front();
          if (code_ch.key_code !== want) begin
            errors++;
            $error("key_code: expected %0d, actual %0d", want, code_ch.key_code);
          end
        end
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: tick requests from the pending queue, in bursts with gaps.
  // Fields only move once the current request has been taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive
    levels_t lv;
    if (!rst_ni) begin
      key_ch.valid <= 1'b0;
      {key_ch.down_n, key_ch.right_n, key_ch.left_n, key_ch.up_n} <= LV_NONE;
    end else if (!key_ch.valid || key_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        key_ch.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        lv = pending.pop_front();
        {key_ch.down_n, key_ch.right_n, key_ch.left_n, key_ch.up_n} <= lv;
        key_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // next burst; about a quarter run straight on with no gap
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        key_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows one of four patterns, each picked at random and held for a random span of cycles
  // ---------------------------------------------------------------------------
  sink_mode_e  sink_mode = READY_ALWAYS;
  int unsigned mode_left = 0;

  always @(negedge clk_i) begin : sink
    logic rdy;
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 120);
    end
    mode_left--;
    case (sink_mode)
      READY_ALWAYS: rdy = 1'b1;
      READY_TOGGLE: rdy = ~code_ch.ready;
      READY_SPARSE: rdy = ($urandom_range(0, 3) != 0);
      default:      rdy = ($urandom_range(0, 15) == 0);  // long stalls
    endcase
    if (!rst_ni) rdy = 1'b0;
    code_ch.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Levels giving key k; buttons below it in priority get random noise
  function automatic levels_t levels_for(logic [kda_pkg::KEY_W-1:0] k);
    levels_t lv;
    lv = levels_t'($urandom_range(0, 15));
    case (k)
      kda_pkg::KEY_UP:    lv[0] = 1'b0;
      kda_pkg::KEY_LEFT:  lv[1:0] = 2'b01;
      kda_pkg::KEY_RIGHT: lv[2:0] = 3'b011;
      kda_pkg::KEY_DOWN:  lv = LV_DOWN;
      default:            lv = LV_NONE;
    endcase
    return lv;
  endfunction

  task automatic add_ticks(levels_t lv, int unsigned n);
    repeat (n) pending.push_back(lv);
    queued_ticks += n;
  endtask

  task automatic add_key(logic [kda_pkg::KEY_W-1:0] k, int unsigned n);
    repeat (n) pending.push_back(levels_for(k));
    queued_ticks += n;
  endtask

  // Mostly held keys of random length, with short releases and glitches
  task automatic add_random_phase(int unsigned n_items, int unsigned max_run);
    int unsigned               left;
    int unsigned               run;
    logic [kda_pkg::KEY_W-1:0] k;
    left = n_items;
    while (left != 0) begin
      k   = kda_pkg::KEY_W'($urandom_range(kda_pkg::KEY_NONE, kda_pkg::KEY_DOWN));
      run = (k == kda_pkg::KEY_NONE) ? $urandom_range(1, 4) : $urandom_range(1, max_run);
      if ($urandom_range(0, 9) == 0) run = 1;  // glitch
      if (run > left) run = left;
      add_key(k, run);
      left -= run;
    end
  endtask

  task automatic write_reg(logic [kda_pkg::CFG_IDX_W-1:0] idx,
                           logic [kda_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [kda_pkg::CFG_W-1:0] db, logic [kda_pkg::CFG_W-1:0] fd,
                          logic [kda_pkg::CFG_W-1:0] rd, logic [kda_pkg::CFG_W-1:0] fs,
                          logic [kda_pkg::CFG_W-1:0] fa);
    write_reg(kda_pkg::CFG_DEBOUNCE_TICKS, db);
    write_reg(kda_pkg::CFG_FIRST_DELAY, fd);
    write_reg(kda_pkg::CFG_REPEAT_DELAY, rd);
    write_reg(kda_pkg::CFG_FAST_DELAY, fs);
    write_reg(kda_pkg::CFG_FAST_AFTER, fa);
  endtask

  // Wait for every tick to be taken and every key code returned, then let the
  // pipeline empty of ticks that gave nothing
  task automatic drain();
    do @(negedge clk_i); while (accepted_ticks != queued_ticks || code_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register value: mostly small, sometimes an extreme
  function automatic logic [kda_pkg::CFG_W-1:0] pick_reg(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return kda_pkg::CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = kda_pkg::CFG_DEBOUNCE_TICKS;
    cfg_ch.data    = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset delays: all buttons down gives up after ten ticks, never repeated
    add_ticks(LV_NONE, 1);
    add_ticks(LV_ALL, 11);
    drain();

    // Zero debounce, zero first and fast delays, plus writes to unused indexes
    set_regs(8'd0, 8'd0, 8'd1, 8'd0, 8'd1);
    write_reg(CFG_SPARE_LO, 8'hff);
    write_reg(CFG_SPARE_HI, 8'h00);
    add_ticks(LV_LEFT, 4);   // press on the first tick, then repeats
    add_ticks(LV_RIGHT, 3);  // change of key
    add_ticks(LV_DOWN, 3);   // timing runs, no repeat
    add_ticks(LV_NONE, 1);   // release
    add_ticks(LV_LR, 2);     // left wins over right
    drain();

    // Longest debounce with one-unit delays: only the press, fast count never reached
    set_regs(8'd255, 8'd1, 8'd1, 8'd1, 8'd255);
    add_key(kda_pkg::KEY_RIGHT, 290);
    add_ticks(LV_NONE, 2);
    drain();

    // Longest waits: only first presses come out
    set_regs(8'd1, 8'd255, 8'd255, 8'd255, 8'd0);
    add_random_phase(100, 20);
    drain();

    // Random settings, mostly short enough for presses and repeats to show
    while (queued_ticks < ITEM_TARGET) begin
      set_regs(pick_reg(1, 8), pick_reg(1, 3), pick_reg(1, 3), pick_reg(1, 2), pick_reg(0, 6));
      add_random_phase(150, 60);
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
